/* hw/rtl/rtsbk_pkg.sv */
// Shared types and constants for the random tour sampler with best keeper.
// Fixed field widths, operation and result codes, sequencer states.
// No dependencies.
`default_nettype none

package rtsbk_pkg;

  localparam int OPC_W  = 2;
  localparam int CITY_W = 4;
  localparam int IN_DIST_W = 16;
  localparam int CCNT_W = 5;
  localparam int STAT_W = 3;
  localparam int COST_W = 21;

  localparam logic [CCNT_W-1:0] CCNT_RESET = CCNT_W'(16);
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_PROPOSE = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_LOADED   = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_DONE     = 3'd3,
    ST_PATH     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CLOSE,
    S_EMIT,
    S_READ,
    S_DRAIN
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [COST_W-1:0]   tour_cost;
    logic                new_best;
    logic [COST_W-1:0]   best_cost;
    logic                best_valid;
    logic [CITY_W-1:0]   path_city;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/rtsbk_if.sv */
// Handshake channels of the tour sampler: input words, result words, config.
// Depends on rtsbk_pkg for field widths.
`default_nettype none

interface rtsbk_item_if;
  logic                             valid;
  logic                             ready;
  logic [rtsbk_pkg::OPC_W-1:0]      opcode;
  logic [rtsbk_pkg::CITY_W-1:0]     from_city;
  logic [rtsbk_pkg::CITY_W-1:0]     to_city;
  logic [rtsbk_pkg::IN_DIST_W-1:0]  distance;
  logic [rtsbk_pkg::CITY_W-1:0]     proposed_city;

  modport source(output valid, output opcode, output from_city, output to_city,
                 output distance, output proposed_city, input ready);
  modport sink(input valid, input opcode, input from_city, input to_city,
               input distance, input proposed_city, output ready);
endinterface

interface rtsbk_result_if;
  logic                          valid;
  logic                          ready;
  logic [rtsbk_pkg::STAT_W-1:0]  status;
  logic [rtsbk_pkg::COST_W-1:0]  tour_cost;
  logic                          new_best;
  logic [rtsbk_pkg::COST_W-1:0]  best_cost;
  logic                          best_valid;
  logic [rtsbk_pkg::CITY_W-1:0]  path_city;
  logic                          last;

  modport source(output valid, output status, output tour_cost, output new_best,
                 output best_cost, output best_valid, output path_city, output last,
                 input ready);
  modport sink(input valid, input status, input tour_cost, input new_best,
               input best_cost, input best_valid, input path_city, input last,
               output ready);
endinterface

interface rtsbk_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rtsbk_pkg::CCNT_W-1:0]  city_count;

  modport source(output valid, output city_count, input ready);
  modport sink(input valid, input city_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/random_tour_sampler_best_keeper_unit.sv */
// Random tour sampler with best keeper: builds tours from city 0 one proposed city at a
// time, keeps the cheapest closed tour and reads it out one city per result word. The
// distance matrix lives in a synchronous RAM and the two path banks in a second one; the
// registered read of the distance RAM sets the timing. A load or a rejected proposal goes
// straight to emit, an accepted one through distance read, accumulate and emit, and the
// one that closes the tour adds a second read for the leg back to city 0. A readout of the
// best tour streams n+1 words after a registered RAM read, one per cycle while the output
// register is free. A new word is taken while an earlier result still waits in the output
// register. Writing city_count restarts the current tour and drops the best record.
// Depends on rtsbk_pkg, rtsbk_if, rtsbk_ram and rtsbk_out_stage.
`default_nettype none

module random_tour_sampler_best_keeper_unit #(
  parameter int MAX_CITIES = 16,
  parameter int DIST_BITS  = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  rtsbk_cfg_if.sink      cfg,
  rtsbk_item_if.sink     item,
  rtsbk_result_if.source result
);

  localparam int CW     = $clog2(MAX_CITIES);
  localparam int NW     = $clog2(MAX_CITIES + 1);
  localparam int DDEPTH = MAX_CITIES * MAX_CITIES;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int PDEPTH = 2 ** (NW + 1);
  localparam int SUM_W  = ((DIST_BITS > rtsbk_pkg::COST_W) ? DIST_BITS : rtsbk_pkg::COST_W) + 1;

  rtsbk_pkg::state_t state, state_next;

  logic [rtsbk_pkg::CCNT_W-1:0] city_count;
  logic [MAX_CITIES-1:0]        visited;
  logic [rtsbk_pkg::CITY_W-1:0] cur_city;
  logic [NW-1:0]                path_len;
  logic [rtsbk_pkg::COST_W-1:0] run_cost;
  logic                         best_sel;
  logic [rtsbk_pkg::COST_W-1:0] best_cost_r;
  logic                         best_present;

  logic [rtsbk_pkg::CITY_W-1:0] prop;
  rtsbk_pkg::status_t           res_status;
  logic [rtsbk_pkg::COST_W-1:0] res_cost;
  logic                         res_nb;

  logic [NW-1:0] rd_idx;
  logic          pend;
  logic          pend_zero;
  logic          pend_last;

  logic [NW-1:0] n_act;
  logic [NW-1:0] len_inc;
  logic          reject;
  logic          load_in_range;
  logic          cfg_wr;

  logic                         dist_we;
  logic [DAW-1:0]               dist_waddr;
  logic [DIST_BITS-1:0]         dist_wdata;
  logic                         dist_re;
  logic [DAW-1:0]               dist_raddr;
  logic [DIST_BITS-1:0]         dist_q;

  logic                         path_we;
  logic [NW:0]                  path_waddr;
  logic                         path_re;
  logic [NW:0]                  path_raddr;
  logic [rtsbk_pkg::CITY_W-1:0] path_q;

  logic [SUM_W-1:0]             cost_sum;
  logic [rtsbk_pkg::COST_W-1:0] cost_sat;

  logic               out_free;
  logic               emit_load;
  logic               load_now;
  logic               issue;
  rtsbk_pkg::result_t res_in;

  function automatic logic [DAW-1:0] dist_addr(input logic [rtsbk_pkg::CITY_W-1:0] row,
                                               input logic [rtsbk_pkg::CITY_W-1:0] col);
    return DAW'(row) * DAW'(MAX_CITIES) + DAW'(col);
  endfunction

  // clamp the configured count into the built range
  always_comb begin
    if (city_count < rtsbk_pkg::CCNT_W'(2)) begin
      n_act = NW'(2);
    end else if (int'(city_count) > MAX_CITIES) begin
      n_act = NW'(MAX_CITIES);
    end else begin
      n_act = NW'(city_count);
    end
  end

  assign len_inc       = path_len + NW'(1);
  assign reject        = (int'(item.proposed_city) >= int'(n_act)) ||
                         visited[CW'(item.proposed_city)];
  assign load_in_range = (int'(item.from_city) < MAX_CITIES) &&
                         (int'(item.to_city) < MAX_CITIES);
  assign cfg_wr        = cfg.valid && cfg.ready;
  assign cfg.ready     = 1'b1;

  // saturating accumulate, shared by the step leg and the closing leg
  assign cost_sum = SUM_W'(run_cost) + SUM_W'(dist_q);
  assign cost_sat = (cost_sum > SUM_W'(rtsbk_pkg::COST_MAX)) ? rtsbk_pkg::COST_MAX
                                                             : rtsbk_pkg::COST_W'(cost_sum);

  assign dist_waddr = dist_addr(item.from_city, item.to_city);
  assign dist_wdata = DIST_BITS'(item.distance);
  assign path_waddr = {~best_sel, path_len};
  assign path_raddr = {best_sel, rd_idx};

  assign load_now = pend && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtsbk_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    dist_we    = 1'b0;
    dist_re    = 1'b0;
    dist_raddr = dist_addr(cur_city, item.proposed_city);
    path_we    = 1'b0;
    path_re    = 1'b0;
    issue      = 1'b0;
    emit_load  = 1'b0;
    case (state)
      rtsbk_pkg::S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.opcode)
            rtsbk_pkg::OP_LOAD: begin
              dist_we    = load_in_range;
              state_next = rtsbk_pkg::S_EMIT;
            end
            rtsbk_pkg::OP_PROPOSE: begin
              if (reject) begin
                state_next = rtsbk_pkg::S_EMIT;
              end else begin
                dist_re    = 1'b1;
                state_next = rtsbk_pkg::S_ADD;
              end
            end
            rtsbk_pkg::OP_READ: begin
              state_next = best_present ? rtsbk_pkg::S_READ : rtsbk_pkg::S_EMIT;
            end
            default: begin
              // unused code: drop the word
            end
          endcase
        end
      end
      rtsbk_pkg::S_ADD: begin
        path_we = 1'b1;
        if (len_inc >= n_act) begin
          dist_re    = 1'b1;
          dist_raddr = dist_addr(prop, '0);
          state_next = rtsbk_pkg::S_CLOSE;
        end else begin
          state_next = rtsbk_pkg::S_EMIT;
        end
      end
      rtsbk_pkg::S_CLOSE: begin
        state_next = rtsbk_pkg::S_EMIT;
      end
      rtsbk_pkg::S_EMIT: begin
        if (out_free) begin
          emit_load  = 1'b1;
          state_next = rtsbk_pkg::S_IDLE;
        end
      end
      rtsbk_pkg::S_READ: begin
        if (!pend || load_now) begin
          issue   = 1'b1;
          path_re = 1'b1;
          if (rd_idx == n_act) begin
            state_next = rtsbk_pkg::S_DRAIN;
          end
        end
      end
      rtsbk_pkg::S_DRAIN: begin
        if (load_now) begin
          state_next = rtsbk_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rtsbk_pkg::S_IDLE;
      end
    endcase
  end

  // tour state, best record and readout control
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count   <= rtsbk_pkg::CCNT_RESET;
      visited      <= MAX_CITIES'(1);
      cur_city     <= '0;
      path_len     <= NW'(1);
      run_cost     <= '0;
      best_sel     <= 1'b0;
      best_cost_r  <= '0;
      best_present <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (issue) begin
        pend <= 1'b1;
      end else if (load_now) begin
        pend <= 1'b0;
      end
      if (cfg_wr) begin
        city_count   <= cfg.city_count;
        best_present <= 1'b0;
        best_cost_r  <= '0;
        visited      <= MAX_CITIES'(1);
        cur_city     <= '0;
        path_len     <= NW'(1);
        run_cost     <= '0;
      end else begin
        case (state)
          rtsbk_pkg::S_ADD: begin
            run_cost            <= cost_sat;
            visited[CW'(prop)]  <= 1'b1;
            path_len            <= len_inc;
            cur_city            <= prop;
          end
          rtsbk_pkg::S_CLOSE: begin
            if (!best_present || cost_sat < best_cost_r) begin
              best_present <= 1'b1;
              best_cost_r  <= cost_sat;
              best_sel     <= ~best_sel;
            end
            visited  <= MAX_CITIES'(1);
            cur_city <= '0;
            path_len <= NW'(1);
            run_cost <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // staged result fields and readout pointer
  always_ff @(posedge clk) begin
    case (state)
      rtsbk_pkg::S_IDLE: begin
        res_cost <= run_cost;
        res_nb   <= 1'b0;
        rd_idx   <= '0;
        prop     <= item.proposed_city;
        if (item.opcode == rtsbk_pkg::OP_LOAD) begin
          res_status <= rtsbk_pkg::ST_LOADED;
        end else if (item.opcode == rtsbk_pkg::OP_PROPOSE) begin
          res_status <= rtsbk_pkg::ST_REJECTED;
        end else begin
          res_status <= rtsbk_pkg::ST_PATH;
        end
      end
      rtsbk_pkg::S_ADD: begin
        res_status <= rtsbk_pkg::ST_ACCEPTED;
        res_cost   <= cost_sat;
      end
      rtsbk_pkg::S_CLOSE: begin
        res_status <= rtsbk_pkg::ST_DONE;
        res_cost   <= cost_sat;
        res_nb     <= !best_present || cost_sat < best_cost_r;
      end
      default: begin
      end
    endcase
    if (issue) begin
      rd_idx    <= rd_idx + NW'(1);
      pend_zero <= (rd_idx == '0) || (rd_idx == n_act);
      pend_last <= rd_idx == n_act;
    end
  end

  // first and last positions of a bank are always city 0
  always_comb begin
    if (load_now) begin
      res_in.status    = rtsbk_pkg::ST_PATH;
      res_in.tour_cost = run_cost;
      res_in.new_best  = 1'b0;
      res_in.path_city = pend_zero ? '0 : path_q;
      res_in.last      = pend_last;
    end else begin
      res_in.status    = res_status;
      res_in.tour_cost = res_cost;
      res_in.new_best  = res_nb;
      res_in.path_city = '0;
      res_in.last      = 1'b1;
    end
    res_in.best_cost  = best_cost_r;
    res_in.best_valid = best_present;
  end

  rtsbk_ram #(
    .WIDTH(DIST_BITS),
    .DEPTH(DDEPTH)
  ) u_dist_ram (
    .clk  (clk),
    .we   (dist_we),
    .waddr(dist_waddr),
    .wdata(dist_wdata),
    .re   (dist_re),
    .raddr(dist_raddr),
    .rdata(dist_q)
  );

  rtsbk_ram #(
    .WIDTH(rtsbk_pkg::CITY_W),
    .DEPTH(PDEPTH)
  ) u_path_ram (
    .clk  (clk),
    .we   (path_we),
    .waddr(path_waddr),
    .wdata(prop),
    .re   (path_re),
    .raddr(path_raddr),
    .rdata(path_q)
  );

  rtsbk_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (emit_load || load_now),
    .res   (res_in),
    .free  (out_free),
    .result(result)
  );

endmodule

`default_nettype wire

/* hw/rtl/rtsbk_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module rtsbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtsbk_out_stage.sv */
// Output register of the tour sampler: holds one result word until taken.
// Depends on rtsbk_pkg (result_t) and rtsbk_result_if.
`default_nettype none

module rtsbk_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire rtsbk_pkg::result_t res,
  output logic                    free,
  rtsbk_result_if.source          result
);

  logic               valid;
  rtsbk_pkg::result_t data;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  // payload: capture only, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign result.valid      = valid;
  assign result.status     = data.status;
  assign result.tour_cost  = data.tour_cost;
  assign result.new_best   = data.new_best;
  assign result.best_cost  = data.best_cost;
  assign result.best_valid = data.best_valid;
  assign result.path_city  = data.path_city;
  assign result.last       = data.last;

endmodule

`default_nettype wire
